[hdl/usb_control_endpoint_responder_unit_macros.svh]
// Assertion macros shared by the checker files of the control endpoint responder.
// Needs nothing else; include it by its bare file name.
`ifndef USB_CONTROL_ENDPOINT_RESPONDER_UNIT_MACROS_SVH
`define USB_CONTROL_ENDPOINT_RESPONDER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UCER_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UCER_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/ucer_pkg.sv]
// Package of the USB control endpoint responder: payload and register types,
// request and response codes, sequencer states, descriptor tables. No dependencies.
package ucer_pkg;

  localparam int EP0_PACKET_BYTES_DEF  = 8;
  localparam int CONFIG_DESC_BYTES_DEF = 32;
  localparam int DEV_DESC_BYTES        = 18;
  localparam int CFG_TABLE_BYTES       = 9 + 9 + 7 + 7;

  // Event types on the input channel.
  localparam logic [2:0] REQ_SETUP    = 3'd0;
  localparam logic [2:0] REQ_EP0_IN   = 3'd1;
  localparam logic [2:0] REQ_EP0_OUT  = 3'd2;
  localparam logic [2:0] REQ_EP1_OUT  = 3'd3;
  localparam logic [2:0] REQ_TICK     = 3'd4;
  localparam logic [2:0] REQ_STATUS   = 3'd5;

  // Response kinds on the result channel.
  localparam logic [2:0] KIND_ACK     = 3'd0;
  localparam logic [2:0] KIND_STALL   = 3'd1;
  localparam logic [2:0] KIND_ZLP     = 3'd2;
  localparam logic [2:0] KIND_DATA    = 3'd3;
  localparam logic [2:0] KIND_SETADDR = 3'd4;
  localparam logic [2:0] KIND_LED     = 3'd5;
  localparam logic [2:0] KIND_EP1_IN  = 3'd6;

  // Standard requests.
  localparam logic [7:0] BREQ_SET_ADDRESS = 8'h05;
  localparam logic [7:0] BREQ_GET_DESC    = 8'h06;
  localparam logic [7:0] BREQ_SET_CONFIG  = 8'h09;
  localparam logic [7:0] SETUP_BYTES      = 8'h08;

  localparam logic [7:0] DTYPE_DEVICE = 8'h01;
  localparam logic [7:0] DTYPE_CONFIG = 8'h02;

  // Descriptor selection.
  localparam logic [1:0] SEL_NONE   = 2'd0;
  localparam logic [1:0] SEL_DEVICE = 2'd1;
  localparam logic [1:0] SEL_CONFIG = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_VENDOR_ID  = 2'd0;
  localparam logic [1:0] CFG_PRODUCT_ID = 2'd1;
  localparam logic [1:0] CFG_RELEASE    = 2'd2;
  localparam logic [1:0] CFG_MAX_POWER  = 2'd3;

  localparam logic [15:0] VENDOR_ID_RST  = 16'h1234;
  localparam logic [15:0] PRODUCT_ID_RST = 16'h5678;
  localparam logic [15:0] RELEASE_RST    = 16'h0001;
  localparam logic [7:0]  MAX_POWER_RST  = 8'd250;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] packet_length;
    logic [7:0] request_code;
    logic [7:0] value_low;
    logic [7:0] value_high;
    logic [7:0] length_low;
    logic [7:0] out_first_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] resp_kind;
    logic [3:0] packet_len;
    logic [7:0] data_byte;
    logic       led_on;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] vendor_id;
    logic [15:0] product_id;
    logic [15:0] device_release;
    logic [7:0]  max_power;
  } cfg_regs_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_PLAN,
    ST_SINGLE,
    ST_STREAM
  } st_t;

  localparam logic [7:0] DEV_TABLE [DEV_DESC_BYTES] = '{
    8'd18, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'd8,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h01
  };

  localparam logic [7:0] CFG_TABLE [CFG_TABLE_BYTES] = '{
    8'd9, 8'h02, 8'h00, 8'h00, 8'h01, 8'h01, 8'h00, 8'h80, 8'h00,
    8'd9, 8'h04, 8'h00, 8'h00, 8'h02, 8'hFF, 8'hFF, 8'hFF, 8'h00,
    8'd7, 8'h05, 8'h81, 8'h03, 8'h01, 8'h00, 8'h06,
    8'd7, 8'h05, 8'h01, 8'h03, 8'h01, 8'h00, 8'h00
  };

  // One descriptor byte; the total length word of the configuration
  // descriptor comes from the build-time size, not from the table.
  function automatic logic [7:0] desc_byte(input logic [1:0] sel, input logic [5:0] idx,
                                           input cfg_regs_t regs,
                                           input logic [5:0] cfg_total);
    logic [7:0] b;
    b = 8'h00;
    if (sel == SEL_DEVICE) begin
      case (idx)
        6'd8:    b = regs.vendor_id[7:0];
        6'd9:    b = regs.vendor_id[15:8];
        6'd10:   b = regs.product_id[7:0];
        6'd11:   b = regs.product_id[15:8];
        6'd12:   b = regs.device_release[7:0];
        6'd13:   b = regs.device_release[15:8];
        default: b = (idx < 6'(DEV_DESC_BYTES)) ? DEV_TABLE[idx[4:0]] : 8'h00;
      endcase
    end else if (sel == SEL_CONFIG) begin
      case (idx)
        6'd2:    b = {2'b00, cfg_total};
        6'd3:    b = 8'h00;
        6'd8:    b = regs.max_power;
        default: b = (idx < 6'(CFG_TABLE_BYTES)) ? CFG_TABLE[idx[4:0]] : 8'h00;
      endcase
    end
    return b;
  endfunction

endpackage

[hdl/ucer_cfg_regs.sv]
// Configuration register file of the control endpoint responder.
// Depends on ucer_pkg for the register type, indexes and reset values.
module ucer_cfg_regs import ucer_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_regs_t   regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;

  // The user must write only while the block is idle; the block itself does not enforce this, and the port never waits.
  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_VENDOR_ID:  regs_nxt.vendor_id      = cfg_data;
        CFG_PRODUCT_ID: regs_nxt.product_id     = cfg_data;
        CFG_RELEASE:    regs_nxt.device_release = cfg_data;
        CFG_MAX_POWER:  regs_nxt.max_power      = cfg_data[7:0];
        default:        regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.vendor_id      <= VENDOR_ID_RST;
      regs_r.product_id     <= PRODUCT_ID_RST;
      regs_r.device_release <= RELEASE_RST;
      regs_r.max_power      <= MAX_POWER_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

[hdl/usb_control_endpoint_responder_unit.sv]
// Top level of the USB control endpoint responder: event decode, descriptor sequencer
// and result register. Depends on ucer_pkg and ucer_cfg_regs.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_item_t
//   out_     output     out_valid/out_stall  out_item_t
//   cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// An event is accepted in idle and decoded, then its results, if any, are loaded;
// a descriptor chunk passes through a planning state first.
// A single byte counter and index adder walks the descriptor one byte per cycle;
// a stalled output register holds the sequencer, and in_stall stays high until the
// last result of the event is loaded. Reset is synchronous and needs no clearing pass.
module usb_control_endpoint_responder_unit import ucer_pkg::*; #(
  parameter int EP0_PACKET_BYTES  = EP0_PACKET_BYTES_DEF,
  parameter int CONFIG_DESC_BYTES = CONFIG_DESC_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [6:0] EP0_W   = 7'(EP0_PACKET_BYTES);
  localparam logic [7:0] CFG_LEN = 8'(CONFIG_DESC_BYTES);

  cfg_regs_t regs;

  ucer_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  st_t        state_r, state_nxt, dec_goto;
  in_item_t   item_r, item_nxt;
  logic [7:0] last_req_r, last_req_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic [5:0] size_r, size_nxt;
  logic [5:0] sent_r, sent_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic       configured_r, configured_nxt;
  logic [7:0] tick_r, tick_nxt;
  logic [5:0] chunk_r, chunk_nxt;
  logic [5:0] idx_r, idx_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [2:0] res_kind_r, res_kind_nxt;
  logic [7:0] res_data_r, res_data_nxt;
  logic       res_led_r, res_led_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;

  logic       accept;
  logic       slot_free;
  logic [5:0] rem;
  logic [5:0] chunk;
  logic       last_beat;
  logic [7:0] cfg_size;

  assign accept    = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rem       = (size_r > sent_r) ? (size_r - sent_r) : 6'd0;
  assign chunk     = ({1'b0, rem} < EP0_W) ? rem : EP0_W[5:0];
  assign last_beat = (cnt_r == (chunk_r - 6'd1));
  assign cfg_size  = (item_r.length_low < CFG_LEN) ? item_r.length_low : CFG_LEN;

  // Event decode: architectural updates and where the sequencer goes next.
  always_comb begin
    dec_goto       = ST_SINGLE;
    last_req_nxt   = last_req_r;
    sel_nxt        = sel_r;
    size_nxt       = size_r;
    sent_nxt       = sent_r;
    addr_nxt       = addr_r;
    configured_nxt = configured_r;
    tick_nxt       = tick_r;
    res_kind_nxt   = res_kind_r;
    res_data_nxt   = res_data_r;
    res_led_nxt    = res_led_r;
    chunk_nxt      = chunk_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    item_nxt       = accept ? in_data : item_r;

    case (state_r)
      ST_DECODE: begin
        res_kind_nxt = KIND_ACK;
        res_data_nxt = 8'h00;
        res_led_nxt  = 1'b0;
        case (item_r.req_type)
          REQ_SETUP: begin
            if (item_r.packet_length != SETUP_BYTES) begin
              res_kind_nxt = KIND_STALL;
            end else begin
              last_req_nxt = item_r.request_code;
              if (item_r.request_code == BREQ_GET_DESC) begin
                if (item_r.value_high == DTYPE_DEVICE) begin
                  sel_nxt  = SEL_DEVICE;
                  size_nxt = 6'(DEV_DESC_BYTES);
                  sent_nxt = 6'd0;
                  dec_goto = ST_PLAN;
                end else if (item_r.value_high == DTYPE_CONFIG) begin
                  sel_nxt  = SEL_CONFIG;
                  size_nxt = cfg_size[5:0];
                  sent_nxt = 6'd0;
                  dec_goto = ST_PLAN;
                end else begin
                  sel_nxt      = SEL_NONE;
                  res_kind_nxt = KIND_STALL;
                end
              end else if (item_r.request_code == BREQ_SET_ADDRESS) begin
                addr_nxt     = item_r.value_low;
                res_kind_nxt = KIND_ZLP;
              end else if (item_r.request_code == BREQ_SET_CONFIG) begin
                configured_nxt = 1'b1;
                res_kind_nxt   = KIND_ZLP;
              end else begin
                res_kind_nxt = KIND_STALL;
              end
            end
          end
          REQ_EP0_IN: begin
            if (last_req_r == BREQ_GET_DESC && sel_r != SEL_NONE) begin
              dec_goto = ST_PLAN;
            end else if (last_req_r == BREQ_SET_ADDRESS) begin
              res_kind_nxt = KIND_SETADDR;
              res_data_nxt = addr_r;
            end
          end
          REQ_EP1_OUT: begin
            if (item_r.packet_length == 8'd1) begin
              res_kind_nxt = KIND_LED;
              res_led_nxt  = item_r.out_first_byte[0];
            end else begin
              dec_goto = ST_IDLE;
            end
          end
          REQ_TICK: begin
            if (configured_r) begin
              res_kind_nxt = KIND_EP1_IN;
              res_data_nxt = tick_r;
              tick_nxt     = tick_r + 8'd1;
            end else begin
              dec_goto = ST_IDLE;
            end
          end
          default: res_kind_nxt = KIND_ACK;
        endcase
      end
      ST_PLAN: begin
        if (chunk == 6'd0) begin
          res_kind_nxt = KIND_ZLP;
          res_data_nxt = 8'h00;
          res_led_nxt  = 1'b0;
        end else begin
          chunk_nxt = chunk;
          idx_nxt   = sent_r;
          cnt_nxt   = 6'd0;
          sent_nxt  = sent_r + chunk;
        end
      end
      ST_STREAM: begin
        if (slot_free) begin
          idx_nxt = idx_r + 6'd1;
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      default: dec_goto = ST_SINGLE;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_DECODE;
      ST_DECODE: state_nxt = dec_goto;
      ST_PLAN:   state_nxt = (chunk == 6'd0) ? ST_SINGLE : ST_STREAM;
      ST_SINGLE: if (slot_free) state_nxt = ST_IDLE;
      ST_STREAM: if (slot_free && last_beat) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Result register loading.
  always_comb begin
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_SINGLE: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.resp_kind  = res_kind_r;
          out_data_nxt.packet_len = 4'd0;
          out_data_nxt.data_byte  = res_data_r;
          out_data_nxt.led_on     = res_led_r;
          out_data_nxt.last       = 1'b1;
        end
      end
      ST_STREAM: begin
        if (slot_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.resp_kind  = KIND_DATA;
          out_data_nxt.packet_len = chunk_r[3:0];
          out_data_nxt.data_byte  = desc_byte(sel_r, idx_r, regs, CFG_LEN[5:0]);
          out_data_nxt.led_on     = 1'b0;
          out_data_nxt.last       = last_beat;
        end
      end
      default: out_data_nxt = out_data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
      last_req_r   <= 8'h00;
      sel_r        <= SEL_NONE;
      size_r       <= 6'd0;
      sent_r       <= 6'd0;
      addr_r       <= 8'h00;
      configured_r <= 1'b0;
      tick_r       <= 8'h00;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      last_req_r   <= last_req_nxt;
      sel_r        <= sel_nxt;
      size_r       <= size_nxt;
      sent_r       <= sent_nxt;
      addr_r       <= addr_nxt;
      configured_r <= configured_nxt;
      tick_r       <= tick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    chunk_r    <= chunk_nxt;
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    res_kind_r <= res_kind_nxt;
    res_data_r <= res_data_nxt;
    res_led_r  <= res_led_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[hdl/ucer_checker.sv]
// Port-level checker of the control endpoint responder, bound to the top level.
// Depends on ucer_pkg and usb_control_endpoint_responder_unit_macros.svh.
`include "usb_control_endpoint_responder_unit_macros.svh"

module ucer_checker import ucer_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled result transfer keeps its payload.
  `UCER_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // The block works on one event at a time.
  `UCER_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "input taken while busy")

  // Only descriptor data comes in multi-result bursts.
  `UCER_ASSERT_SAME(a_single_is_last, clk, rst_n, out_valid && out_data.resp_kind != KIND_DATA, out_data.last, "non-data result not last")

  // The LED bit is only meaningful on an LED result.
  `UCER_ASSERT_SAME(a_led_only, clk, rst_n, out_valid && out_data.resp_kind != KIND_LED, !out_data.led_on, "led bit set on wrong kind")

endmodule

bind usb_control_endpoint_responder_unit ucer_checker u_ucer_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
